>>> hw/rtl/stbb_pkg.sv
`timescale 1ns / 1ps

package stbb_pkg;

	// Sizing of the block.
	localparam int MAX_KEY_BYTES  = 32;
	localparam int MAX_RESTARTS   = 63;
	localparam int KEY_LEN_W      = 6;
	localparam int VALUE_LEN_W    = 32;
	localparam int WORD_W         = 32;
	localparam int COUNT_W        = 3;
	localparam int BYTES_PER_WORD = 4;
	localparam int INTERVAL_W     = 16;
	localparam int INTERVAL_RESET = 16;

	// Key store: two banks, each deep enough for the longest key.
	localparam int KEY_IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int KEY_CNT_W = $clog2(MAX_KEY_BYTES + 1);
	localparam int KEY_AW    = KEY_IDX_W + 1;
	localparam int KEY_DEPTH = 2 ** KEY_AW;

	// Restart offset store.
	localparam int RST_IDX_W = (MAX_RESTARTS > 1) ? $clog2(MAX_RESTARTS) : 1;
	localparam int RST_CNT_W = $clog2(MAX_RESTARTS + 1);

	typedef enum logic [1:0] {
		ACT_BEGIN  = 2'd0,
		ACT_KEY    = 2'd1,
		ACT_VALUE  = 2'd2,
		ACT_FINISH = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_KEY_LONG = 2'd1,
		ERR_RST_FULL = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_KEY_CMP,
		ST_HDR_SHARED,
		ST_HDR_UNIQUE,
		ST_HDR_VALUE,
		ST_KEY_ADDR,
		ST_KEY_DATA,
		ST_KEY_EMIT,
		ST_VAL,
		ST_RST_ADDR,
		ST_RST_EMIT,
		ST_RST_COUNT
	} state_t;

	typedef struct packed {
		action_t                action;
		logic [KEY_LEN_W-1:0]   key_len;
		logic [VALUE_LEN_W-1:0] value_len;
		logic [7:0]             data_byte;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0]  out_word;
		logic [COUNT_W-1:0] byte_count;
		logic               run_last;
		err_t               error_code;
		logic [WORD_W-1:0]  bytes_so_far;
	} res_item_t;

	// Key store access for one cycle.
	typedef struct packed {
		logic              wr_en;
		logic [KEY_AW-1:0] wr_addr;
		logic [KEY_AW-1:0] rd_addr;
		logic [7:0]        data;
	} key_req_t;

	typedef struct packed {
		logic [7:0] rd_byte;
		logic       eq;
	} key_rsp_t;

endpackage

>>> hw/rtl/stbb_key_store.sv
`timescale 1ns / 1ps

module stbb_key_store (
	input  logic              clk,
	input  stbb_pkg::key_req_t req,
	output stbb_pkg::key_rsp_t rsp
);

	logic [7:0] mem_q [stbb_pkg::KEY_DEPTH];
	logic [7:0] rd_q;
	logic [7:0] byte_q;

	// Write the incoming key byte and keep a copy for the prefix compare.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.data;
			byte_q             <= req.data;
		end
		rd_q <= mem_q[req.rd_addr];
	end

	// Compare the byte just written with the previous key's byte read alongside it.
	assign rsp.rd_byte = rd_q;
	assign rsp.eq      = (rd_q == byte_q);

endmodule

>>> hw/rtl/sorted_table_block_builder.sv
// Sorted-table block builder: one item at a time under a small sequencer, taken only in idle.
// Key byte: key store read and compare, in ST_KEY_CMP after the write. Value byte: one result.
// Header words: one state each. Unique key bytes: address and data state each; one emit per word.
// Finish: per restart offset an address and an emit state (store read port), then the count.
// Reset (arst_n low, asynchronous) clears control state and sets the restart interval to 16;
// the key and restart stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module sorted_table_block_builder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [stbb_pkg::INTERVAL_W-1:0]       cfg_wr_data,
	input  stbb_pkg::in_item_t                    item,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	output stbb_pkg::res_item_t                   result,
	output logic                                  result_valid,
	input  logic                                  result_stall
);

	stbb_pkg::state_t state_q, state_d;

	logic [stbb_pkg::INTERVAL_W-1:0]  interval_q;
	logic [stbb_pkg::INTERVAL_W-1:0]  entries_q;
	logic                             bank_q;
	logic [stbb_pkg::KEY_CNT_W-1:0]   prev_len_q;
	logic [stbb_pkg::KEY_CNT_W-1:0]   cur_len_q;
	logic [stbb_pkg::KEY_CNT_W-1:0]   kbs_q;
	logic [stbb_pkg::KEY_CNT_W-1:0]   shared_q;
	logic                             match_q;
	logic [stbb_pkg::VALUE_LEN_W-1:0] pending_q;
	logic [stbb_pkg::WORD_W-1:0]      offset_q;
	logic [stbb_pkg::RST_CNT_W-1:0]   rcount_q;
	logic [stbb_pkg::RST_CNT_W-1:0]   r_q;
	logic [stbb_pkg::KEY_CNT_W-1:0]   i_q;
	logic [stbb_pkg::COUNT_W-1:0]     wcnt_q;
	stbb_pkg::err_t                   err_q;
	logic                             hdr_after_q;
	logic [7:0]                       b_q;
	logic [stbb_pkg::WORD_W-1:0]      word_q;
	logic [stbb_pkg::WORD_W-1:0]      rst_mem_q [stbb_pkg::MAX_RESTARTS];
	logic [stbb_pkg::WORD_W-1:0]      rst_rdata_q;
	logic                             result_valid_q;
	stbb_pkg::res_item_t              result_q;

	stbb_pkg::key_req_t key_req;
	stbb_pkg::key_rsp_t key_rsp;

	logic                             item_accept;
	logic                             too_long;
	logic                             restart_due;
	logic                             restart_full;
	logic                             rst_wr;
	logic                             key_take;
	logic                             val_take;
	logic                             cmp_hit;
	logic [stbb_pkg::KEY_CNT_W-1:0]   kbs_inc;
	logic [stbb_pkg::KEY_CNT_W-1:0]   i_inc;
	logic [stbb_pkg::COUNT_W-1:0]     wcnt_inc;
	logic [stbb_pkg::RST_CNT_W-1:0]   r_inc;
	logic [stbb_pkg::KEY_CNT_W-1:0]   unique_len;
	logic                             out_ok;
	logic                             emit_en;
	logic                             emit_fire;
	logic                             emit_last;
	logic [stbb_pkg::WORD_W-1:0]      emit_word;
	logic [stbb_pkg::COUNT_W-1:0]     emit_cnt;
	stbb_pkg::err_t                   emit_err;
	logic [stbb_pkg::WORD_W-1:0]      bytes_so_far;
	logic                             key_complete;
	logic                             block_clear;

	// Decode of the accepted item.
	assign item_stall   = (state_q != stbb_pkg::ST_IDLE);
	assign item_accept  = item_valid && !item_stall;
	assign too_long     = (item.key_len > stbb_pkg::KEY_LEN_W'(stbb_pkg::MAX_KEY_BYTES));
	assign restart_due  = (entries_q >= interval_q);
	assign restart_full = (rcount_q >= stbb_pkg::RST_CNT_W'(stbb_pkg::MAX_RESTARTS));
	assign rst_wr       = item_accept && (item.action == stbb_pkg::ACT_BEGIN) && !too_long
	                      && restart_due && !restart_full;
	assign key_take     = (kbs_q < cur_len_q);
	assign val_take     = (kbs_q == cur_len_q) && (pending_q != '0);

	assign kbs_inc    = kbs_q + stbb_pkg::KEY_CNT_W'(1);
	assign i_inc      = i_q + stbb_pkg::KEY_CNT_W'(1);
	assign wcnt_inc   = wcnt_q + stbb_pkg::COUNT_W'(1);
	assign r_inc      = r_q + stbb_pkg::RST_CNT_W'(1);
	assign unique_len = cur_len_q - shared_q;
	assign cmp_hit    = match_q && (kbs_q < prev_len_q) && key_rsp.eq;

	// Key store: the current key goes to the other bank from the previous key.
	always_comb begin
		key_req.wr_en   = item_accept && (item.action == stbb_pkg::ACT_KEY) && key_take;
		key_req.wr_addr = {~bank_q, kbs_q[stbb_pkg::KEY_IDX_W-1:0]};
		key_req.data    = item.data_byte;
		if (state_q == stbb_pkg::ST_IDLE) begin
			key_req.rd_addr = {bank_q, kbs_q[stbb_pkg::KEY_IDX_W-1:0]};
		end else begin
			key_req.rd_addr = {~bank_q, i_q[stbb_pkg::KEY_IDX_W-1:0]};
		end
	end

	stbb_key_store u_key_store (
		.clk (clk),
		.req (key_req),
		.rsp (key_rsp)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stbb_pkg::ST_IDLE: begin
				if (item_accept) begin
					unique case (item.action)
						stbb_pkg::ACT_BEGIN: begin
							if (too_long || (restart_due && restart_full)) begin
								state_d = stbb_pkg::ST_ERR;
							end else if (item.key_len == '0) begin
								state_d = stbb_pkg::ST_HDR_SHARED;
							end
						end
						stbb_pkg::ACT_KEY: begin
							if (key_take) state_d = stbb_pkg::ST_KEY_CMP;
						end
						stbb_pkg::ACT_VALUE: begin
							if (val_take) state_d = stbb_pkg::ST_VAL;
						end
						stbb_pkg::ACT_FINISH: state_d = stbb_pkg::ST_RST_ADDR;
						default: state_d = stbb_pkg::ST_IDLE;
					endcase
				end
			end
			stbb_pkg::ST_ERR: begin
				if (out_ok) begin
					state_d = hdr_after_q ? stbb_pkg::ST_HDR_SHARED : stbb_pkg::ST_IDLE;
				end
			end
			stbb_pkg::ST_KEY_CMP: begin
				state_d = (kbs_inc == cur_len_q) ? stbb_pkg::ST_HDR_SHARED : stbb_pkg::ST_IDLE;
			end
			stbb_pkg::ST_HDR_SHARED: if (out_ok) state_d = stbb_pkg::ST_HDR_UNIQUE;
			stbb_pkg::ST_HDR_UNIQUE: if (out_ok) state_d = stbb_pkg::ST_HDR_VALUE;
			stbb_pkg::ST_HDR_VALUE: begin
				if (out_ok) begin
					state_d = (unique_len == '0) ? stbb_pkg::ST_IDLE : stbb_pkg::ST_KEY_ADDR;
				end
			end
			stbb_pkg::ST_KEY_ADDR: state_d = stbb_pkg::ST_KEY_DATA;
			stbb_pkg::ST_KEY_DATA: begin
				if ((wcnt_inc == stbb_pkg::COUNT_W'(stbb_pkg::BYTES_PER_WORD))
				    || (i_inc == cur_len_q)) begin
					state_d = stbb_pkg::ST_KEY_EMIT;
				end else begin
					state_d = stbb_pkg::ST_KEY_ADDR;
				end
			end
			stbb_pkg::ST_KEY_EMIT: begin
				if (out_ok) begin
					state_d = (i_q == cur_len_q) ? stbb_pkg::ST_IDLE : stbb_pkg::ST_KEY_ADDR;
				end
			end
			stbb_pkg::ST_VAL: if (out_ok) state_d = stbb_pkg::ST_IDLE;
			stbb_pkg::ST_RST_ADDR: state_d = stbb_pkg::ST_RST_EMIT;
			stbb_pkg::ST_RST_EMIT: begin
				if (out_ok) begin
					state_d = (r_inc == rcount_q) ? stbb_pkg::ST_RST_COUNT : stbb_pkg::ST_RST_ADDR;
				end
			end
			stbb_pkg::ST_RST_COUNT: if (out_ok) state_d = stbb_pkg::ST_IDLE;
			default: state_d = stbb_pkg::ST_IDLE;
		endcase
	end

	// Result produced in each state.
	always_comb begin
		emit_en   = 1'b0;
		emit_word = '0;
		emit_cnt  = stbb_pkg::COUNT_W'(stbb_pkg::BYTES_PER_WORD);
		emit_err  = stbb_pkg::ERR_NONE;
		emit_last = 1'b0;
		unique case (state_q)
			stbb_pkg::ST_ERR: begin
				emit_en   = 1'b1;
				emit_cnt  = '0;
				emit_err  = err_q;
				emit_last = !hdr_after_q;
			end
			stbb_pkg::ST_HDR_SHARED: begin
				emit_en   = 1'b1;
				emit_word = stbb_pkg::WORD_W'(shared_q);
			end
			stbb_pkg::ST_HDR_UNIQUE: begin
				emit_en   = 1'b1;
				emit_word = stbb_pkg::WORD_W'(unique_len);
			end
			stbb_pkg::ST_HDR_VALUE: begin
				emit_en   = 1'b1;
				emit_word = pending_q;
				emit_last = (unique_len == '0);
			end
			stbb_pkg::ST_KEY_EMIT: begin
				emit_en   = 1'b1;
				emit_word = word_q;
				emit_cnt  = wcnt_q;
				emit_last = (i_q == cur_len_q);
			end
			stbb_pkg::ST_VAL: begin
				emit_en   = 1'b1;
				emit_word = stbb_pkg::WORD_W'(b_q);
				emit_cnt  = stbb_pkg::COUNT_W'(1);
				emit_last = 1'b1;
			end
			stbb_pkg::ST_RST_EMIT: begin
				emit_en   = 1'b1;
				emit_word = (r_q == '0) ? '0 : rst_rdata_q;
			end
			stbb_pkg::ST_RST_COUNT: begin
				emit_en   = 1'b1;
				emit_word = stbb_pkg::WORD_W'(rcount_q);
				emit_last = 1'b1;
			end
			default: emit_en = 1'b0;
		endcase
	end

	// The one offset adder, shared by every result.
	assign out_ok       = !result_valid_q || !result_stall;
	assign emit_fire    = emit_en && out_ok;
	assign bytes_so_far = offset_q + stbb_pkg::WORD_W'(emit_cnt);
	assign key_complete = emit_fire && emit_last
	                      && ((state_q == stbb_pkg::ST_HDR_VALUE)
	                          || (state_q == stbb_pkg::ST_KEY_EMIT));
	assign block_clear  = emit_fire && (state_q == stbb_pkg::ST_RST_COUNT);

	// Sequencer and block state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stbb_pkg::ST_IDLE;
			interval_q  <= stbb_pkg::INTERVAL_W'(stbb_pkg::INTERVAL_RESET);
			entries_q   <= '0;
			bank_q      <= 1'b0;
			prev_len_q  <= '0;
			cur_len_q   <= '0;
			kbs_q       <= '0;
			shared_q    <= '0;
			match_q     <= 1'b1;
			pending_q   <= '0;
			offset_q    <= '0;
			rcount_q    <= stbb_pkg::RST_CNT_W'(1);
			r_q         <= '0;
			i_q         <= '0;
			wcnt_q      <= '0;
			err_q       <= stbb_pkg::ERR_NONE;
			hdr_after_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) interval_q <= cfg_wr_data;

			// Accepted item.
			if (item_accept) begin
				case (item.action)
					stbb_pkg::ACT_BEGIN: begin
						kbs_q       <= '0;
						hdr_after_q <= !too_long && (item.key_len == '0);
						if (too_long) begin
							cur_len_q <= '0;
							pending_q <= '0;
							err_q     <= stbb_pkg::ERR_KEY_LONG;
						end else begin
							cur_len_q <= stbb_pkg::KEY_CNT_W'(item.key_len);
							pending_q <= item.value_len;
							shared_q  <= '0;
							match_q   <= 1'b1;
							err_q     <= stbb_pkg::ERR_RST_FULL;
							if (restart_due) begin
								prev_len_q <= '0;
								entries_q  <= '0;
								if (!restart_full) rcount_q <= rcount_q + stbb_pkg::RST_CNT_W'(1);
							end
						end
					end
					stbb_pkg::ACT_VALUE: begin
						if (val_take) pending_q <= pending_q - stbb_pkg::VALUE_LEN_W'(1);
					end
					stbb_pkg::ACT_FINISH: r_q <= '0;
					default: ;
				endcase
			end

			// Per-state counters.
			case (state_q)
				stbb_pkg::ST_KEY_CMP: begin
					if (cmp_hit) begin
						shared_q <= shared_q + stbb_pkg::KEY_CNT_W'(1);
					end else begin
						match_q <= 1'b0;
					end
					kbs_q <= kbs_inc;
				end
				stbb_pkg::ST_HDR_VALUE: begin
					if (emit_fire) begin
						i_q    <= shared_q;
						wcnt_q <= '0;
					end
				end
				stbb_pkg::ST_KEY_DATA: begin
					i_q    <= i_inc;
					wcnt_q <= wcnt_inc;
				end
				stbb_pkg::ST_KEY_EMIT: if (emit_fire) wcnt_q <= '0;
				stbb_pkg::ST_RST_EMIT: if (emit_fire) r_q <= r_inc;
				default: ;
			endcase

			if (emit_fire && !block_clear) offset_q <= bytes_so_far;

			// Entry finished: its key becomes the previous key.
			if (key_complete) begin
				bank_q     <= ~bank_q;
				prev_len_q <= cur_len_q;
				entries_q  <= entries_q + stbb_pkg::INTERVAL_W'(1);
			end

			// Finish: start a fresh block.
			if (block_clear) begin
				rcount_q   <= stbb_pkg::RST_CNT_W'(1);
				prev_len_q <= '0;
				entries_q  <= '0;
				offset_q   <= '0;
				cur_len_q  <= '0;
				kbs_q      <= '0;
				shared_q   <= '0;
				match_q    <= 1'b1;
				pending_q  <= '0;
			end
		end
	end

	// Value byte and key word assembly.
	always_ff @(posedge clk) begin
		if (item_accept) b_q <= item.data_byte;
		if (state_q == stbb_pkg::ST_KEY_DATA) begin
			word_q[{wcnt_q[1:0], 3'b000} +: 8] <= key_rsp.rd_byte;
		end else if (emit_fire && ((state_q == stbb_pkg::ST_HDR_VALUE)
		                           || (state_q == stbb_pkg::ST_KEY_EMIT))) begin
			word_q <= '0;
		end
	end

	// Restart offset store. Entry zero is never written; offset zero is sent in its place.
	always_ff @(posedge clk) begin
		if (rst_wr) rst_mem_q[rcount_q[stbb_pkg::RST_IDX_W-1:0]] <= offset_q;
		rst_rdata_q <= rst_mem_q[r_q[stbb_pkg::RST_IDX_W-1:0]];
	end

	// Output register: holds a result while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			result_q.out_word     <= emit_word;
			result_q.byte_count   <= emit_cnt;
			result_q.run_last     <= emit_last;
			result_q.error_code   <= emit_err;
			result_q.bytes_so_far <= bytes_so_far;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

`ifndef NO_ASSERTIONS
	a_kbs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(kbs_q <= cur_len_q) && ((cur_len_q == '0) || (shared_q <= kbs_q)))
		else $error("key byte count or shared prefix beyond key length");

	a_rcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rcount_q >= stbb_pkg::RST_CNT_W'(1))
		&& (rcount_q <= stbb_pkg::RST_CNT_W'(stbb_pkg::MAX_RESTARTS)))
		else $error("restart count out of range");

	a_empty_is_error: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.byte_count == '0)) |-> (result.error_code != stbb_pkg::ERR_NONE))
		else $error("result without bytes carries no error");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		block_clear |=> ((offset_q == '0) && (rcount_q == stbb_pkg::RST_CNT_W'(1))))
		else $error("finish did not clear the block");

	a_word_fill: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= stbb_pkg::COUNT_W'(stbb_pkg::BYTES_PER_WORD))
		else $error("key word overfilled");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int ITEMS         = 480;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD     = 300;
	localparam int LIMIT_CYCLES  = 20_000_000;
	localparam int REPORT_CAP    = 200;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [stbb_pkg::INTERVAL_W-1:0] cfg_wr_data;
	stbb_pkg::in_item_t              item_bus;
	logic                            item_valid;
	logic                            item_stall;
	stbb_pkg::res_item_t             result_bus;
	logic                            result_valid;
	logic                            result_stall;

	// Random idling on both sides is switched per phase.
	bit idling = 1'b1;
	// Asks the receiving side for one long hold-off.
	bit hold_req = 1'b0;

	int transfers;
	int noise_transfers;
	int settings;
	int cycle_count;
	bit [7:0] last_key[$];

	sorted_table_block_builder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item        (item_bus),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.result      (result_bus),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	// Tracks the block image being built and the result transfers still owed.
	class block_scoreboard;
		bit [stbb_pkg::INTERVAL_W-1:0] interval;
		bit [7:0]                      key_bytes [2][64];
		bit                            bank;
		bit [5:0]                      prev_len;
		bit [5:0]                      cur_len;
		bit [5:0]                      seen;
		bit [5:0]                      shared;
		bit                            matching;
		bit [31:0]                     pend_val;
		bit [15:0]                     since_restart;
		bit [31:0]                     offset;
		bit [31:0]                     restarts [stbb_pkg::MAX_RESTARTS];
		bit [5:0]                      n_restarts;
		stbb_pkg::res_item_t           due_results[$];
		int                            errors;
		int                            checked;
		int                            finishes;
		int                            key_long_flags;
		int                            table_full_flags;

		function new();
			interval = stbb_pkg::INTERVAL_W'(stbb_pkg::INTERVAL_RESET);
			bank = 1'b0;
			clear_block();
		endfunction

		function void set_interval(bit [stbb_pkg::INTERVAL_W-1:0] v);
			interval = v;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void clear_block();
			foreach (restarts[i]) restarts[i] = 32'd0;
			n_restarts = 6'd1;
			prev_len = 6'd0;
			since_restart = 16'd0;
			offset = 32'd0;
			cur_len = 6'd0;
			seen = 6'd0;
			shared = 6'd0;
			matching = 1'b1;
			pend_val = 32'd0;
		endfunction

		// Every emitted word adds its valid bytes to the running block size.
		function void push_result(bit [31:0] word, bit [2:0] cnt, stbb_pkg::err_t err);
			stbb_pkg::res_item_t r;
			offset += 32'(cnt);
			r.out_word = word;
			r.byte_count = cnt;
			r.run_last = 1'b0;
			r.error_code = err;
			r.bytes_so_far = offset;
			due_results.insert(due_results.size(), r);
		endfunction

		// Header words, then the unique tail of the key packed four bytes per word.
		function void close_key();
			bit        nb;
			bit [31:0] word;
			int        cnt;
			int        i;
			nb = ~bank;
			push_result(32'(shared), 3'd4, stbb_pkg::ERR_NONE);
			push_result(32'(cur_len - shared), 3'd4, stbb_pkg::ERR_NONE);
			push_result(pend_val, 3'd4, stbb_pkg::ERR_NONE);
			i = int'(shared);
			while (i < int'(cur_len)) begin
				word = 32'd0;
				cnt = 0;
				while (cnt < 4 && i < int'(cur_len)) begin
					word |= 32'(key_bytes[nb][i]) << (8 * cnt);
					cnt++;
					i++;
				end
				push_result(word, 3'(cnt), stbb_pkg::ERR_NONE);
			end
			bank = nb;
			prev_len = cur_len;
			since_restart++;
		endfunction

		// Works out the results owed for one accepted input transfer.
		function void predict_block_output(stbb_pkg::in_item_t it);
			int first;
			first = due_results.size();
			case (it.action)
				stbb_pkg::ACT_BEGIN: begin
					cur_len = 6'd0;
					seen = 6'd0;
					pend_val = 32'd0;
					if (int'(it.key_len) > stbb_pkg::MAX_KEY_BYTES) begin
						push_result(32'd0, 3'd0, stbb_pkg::ERR_KEY_LONG);
						key_long_flags++;
					end else begin
						if (since_restart >= interval) begin
							prev_len = 6'd0;
							since_restart = 16'd0;
							if (int'(n_restarts) < stbb_pkg::MAX_RESTARTS) begin
								restarts[n_restarts] = offset;
								n_restarts++;
							end else begin
								push_result(32'd0, 3'd0, stbb_pkg::ERR_RST_FULL);
								table_full_flags++;
							end
						end
						cur_len = it.key_len;
						shared = 6'd0;
						matching = 1'b1;
						pend_val = it.value_len;
						if (it.key_len == 6'd0) close_key();
					end
				end
				stbb_pkg::ACT_KEY: begin
					if (seen < cur_len) begin
						key_bytes[~bank][seen] = it.data_byte;
						if (matching && seen < prev_len && key_bytes[bank][seen] == it.data_byte)
							shared++;
						else
							matching = 1'b0;
						seen++;
						if (seen == cur_len) close_key();
					end
				end
				stbb_pkg::ACT_VALUE: begin
					if (seen == cur_len && pend_val != 32'd0) begin
						pend_val--;
						push_result(32'(it.data_byte), 3'd1, stbb_pkg::ERR_NONE);
					end
				end
				default: begin
					for (int i = 0; i < int'(n_restarts); i++)
						push_result(restarts[i], 3'd4, stbb_pkg::ERR_NONE);
					push_result(32'(n_restarts), 3'd4, stbb_pkg::ERR_NONE);
					clear_block();
					finishes++;
				end
			endcase
			if (due_results.size() > first) due_results[$].run_last = 1'b1;
		endfunction

		// Compares one result transfer with the oldest one owed.
		function void check_result(stbb_pkg::res_item_t got);
			stbb_pkg::res_item_t want;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$error("unexpected result transfer: out_word %h", got.out_word);
				return;
			end
			want = due_results.pop_front();
			checked++;
			if (got.out_word !== want.out_word) begin
				errors++;
				if (errors <= REPORT_CAP)
					$error("out_word: expected %h, got %h", want.out_word, got.out_word);
			end
			if (got.byte_count !== want.byte_count) begin
				errors++;
				if (errors <= REPORT_CAP)
					$error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
			end
			if (got.run_last !== want.run_last) begin
				errors++;
				if (errors <= REPORT_CAP)
					$error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
			end
			if (got.error_code !== want.error_code) begin
				errors++;
				if (errors <= REPORT_CAP)
					$error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
			end
			if (got.bytes_so_far !== want.bytes_so_far) begin
				errors++;
				if (errors <= REPORT_CAP)
					$error("bytes_so_far: expected %0d, got %0d",
						want.bytes_so_far, got.bytes_so_far);
			end
		endfunction
	endclass

	block_scoreboard sb = new();

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Ends a hung run.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Every accepted result transfer is checked at the edge where it happens.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
			sb.check_result(result_bus);
	end

	// Receiving side: runs of stall and no stall, plus one long hold-off on request.
	initial begin : result_side
		int run_left;
		int hold_left;
		int r;
		bit level;
		run_left = 0;
		hold_left = 0;
		level = 1'b0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				if (run_left == 0) begin
					r = int'($urandom_range(99, 0));
					if (!idling || r < 55) begin
						level = 1'b0;
						run_left = int'($urandom_range(8, 1));
					end else if (r < 94) begin
						level = 1'b1;
						run_left = int'($urandom_range(3, 1));
					end else begin
						level = 1'b1;
						run_left = int'($urandom_range(30, 8));
					end
				end
				run_left--;
				result_stall <= level;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (!idling) return 0;
		r = int'($urandom_range(99, 0));
		if (r < 65) return 0;
		if (r < 95) return int'($urandom_range(3, 1));
		return int'($urandom_range(30, 8));
	endfunction

	// Offers one item and holds it until the block takes the transfer.
	task automatic send(input stbb_pkg::action_t act, input bit [5:0] klen,
			input bit [31:0] vlen, input bit [7:0] b);
		stbb_pkg::in_item_t it;
		int gap;
		it.action = act;
		it.key_len = klen;
		it.value_len = vlen;
		it.data_byte = b;
		item_bus <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall !== 1'b0);
		sb.predict_block_output(it);
		transfers++;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits until every owed result has arrived and the block has gone quiet.
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_interval(input bit [stbb_pkg::INTERVAL_W-1:0] v);
		cfg_wr_data <= v;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_interval(v);
		settings++;
	endtask

	// One entry: begin, key bytes that often reuse a prefix of the last key, value bytes.
	task automatic send_entry(input int kl, input bit [31:0] vl, input int nkey, input int nval);
		bit [7:0] this_key[$];
		bit [7:0] k;
		int share;
		share = (kl < last_key.size()) ? kl : last_key.size();
		share = int'($urandom_range(share, 0));
		send(stbb_pkg::ACT_BEGIN, 6'(kl), vl, 8'($urandom));
		for (int i = 0; i < nkey; i++) begin
			if (i < share)
				k = last_key[i];
			else if ($urandom_range(1, 0) == 1)
				k = 8'($urandom);
			else
				k = 8'(8'h41 + $urandom_range(2, 0));
			if (i < kl) this_key.insert(this_key.size(), k);
			send(stbb_pkg::ACT_KEY, 6'($urandom), $urandom, k);
		end
		for (int i = 0; i < nval; i++)
			send(stbb_pkg::ACT_VALUE, 6'($urandom), $urandom, 8'($urandom));
		if (nkey >= kl && kl <= stbb_pkg::MAX_KEY_BYTES) last_key = this_key;
	endtask

	task automatic random_entry();
		int kl;
		bit [31:0] vl;
		int nkey;
		int nval;
		int r;
		r = int'($urandom_range(99, 0));
		kl = (r < 10) ? stbb_pkg::MAX_KEY_BYTES : (r < 20) ? 0 : int'($urandom_range(12, 1));
		r = int'($urandom_range(99, 0));
		if (r < 70)
			vl = 32'($urandom_range(5, 0));
		else if (r < 85)
			vl = 32'($urandom_range(24, 6));
		else
			vl = $urandom;
		nkey = kl;
		nval = (vl <= 32'd24) ? int'(vl) : int'($urandom_range(6, 0));
		r = int'($urandom_range(99, 0));
		// A few entries are broken off early or carry stray bytes.
		if (r < 5 && kl > 0)
			nkey = int'($urandom_range(kl - 1, 0));
		else if (r < 9)
			nkey = kl + 1;
		else if (r < 14)
			nval = nval + int'($urandom_range(2, 1));
		send_entry(kl, vl, nkey, nval);
	endtask

	task automatic noise_item();
		case ($urandom_range(3, 0))
			0: send(stbb_pkg::ACT_BEGIN, 6'($urandom_range(63, stbb_pkg::MAX_KEY_BYTES + 1)),
				$urandom, 8'($urandom));
			1: send(stbb_pkg::ACT_KEY, 6'($urandom), $urandom, 8'($urandom));
			2: send(stbb_pkg::ACT_VALUE, 6'($urandom), $urandom, 8'($urandom));
			default: send(stbb_pkg::action_t'($urandom_range(3, 0)), 6'($urandom), $urandom,
				8'($urandom));
		endcase
		noise_transfers++;
	endtask

	// Mostly well-formed entries with the odd finish and some noise; closes the block at the end.
	task automatic random_phase(input int budget);
		int stop_at;
		int r;
		stop_at = transfers - noise_transfers + budget;
		while (transfers - noise_transfers < stop_at) begin
			r = int'($urandom_range(99, 0));
			if (r < 75)
				random_entry();
			else if (r < 83)
				send(stbb_pkg::ACT_FINISH, 6'($urandom), $urandom, 8'($urandom));
			else
				noise_item();
		end
		send(stbb_pkg::ACT_FINISH, 6'($urandom), $urandom, 8'($urandom));
	endtask

	initial begin : stimulus
		bit [stbb_pkg::INTERVAL_W-1:0] iv;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		item_bus <= '0;
		item_valid <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset interval, without idling.
		idling = 1'b0;
		// Empty key: the header goes out at once.
		send(stbb_pkg::ACT_BEGIN, 6'd0, 32'd0, 8'h00);
		// A three-byte key and two value bytes at the byte extremes.
		send(stbb_pkg::ACT_BEGIN, 6'd3, 32'd2, 8'hFF);
		send(stbb_pkg::ACT_KEY, 6'h3F, 32'hFFFF_FFFF, 8'h00);
		send(stbb_pkg::ACT_KEY, 6'h00, 32'h0000_0000, 8'hFF);
		send(stbb_pkg::ACT_KEY, 6'h2A, 32'h5555_5555, 8'hA5);
		send(stbb_pkg::ACT_VALUE, 6'h15, 32'hAAAA_AAAA, 8'h00);
		send(stbb_pkg::ACT_VALUE, 6'h3F, 32'hFFFF_FFFF, 8'hFF);
		// The whole key is shared with the previous one; the long value is abandoned.
		send(stbb_pkg::ACT_BEGIN, 6'd2, 32'hFFFF_FFFE, 8'h00);
		send(stbb_pkg::ACT_KEY, 6'd0, 32'd0, 8'h00);
		send(stbb_pkg::ACT_KEY, 6'd0, 32'd0, 8'hFF);
		send(stbb_pkg::ACT_VALUE, 6'd0, 32'd0, 8'h5A);
		// Stray key byte while value bytes are pending.
		send(stbb_pkg::ACT_KEY, 6'd0, 32'd0, 8'h77);
		// Over-long keys are flagged and their bytes ignored.
		send(stbb_pkg::ACT_BEGIN, 6'd33, 32'd1, 8'h00);
		send(stbb_pkg::ACT_KEY, 6'd0, 32'd0, 8'h11);
		send(stbb_pkg::ACT_VALUE, 6'd0, 32'd0, 8'h22);
		send(stbb_pkg::ACT_BEGIN, 6'h3F, 32'hFFFF_FFFF, 8'hFF);
		// Finish in the middle of a key, then finish an empty block.
		send(stbb_pkg::ACT_BEGIN, 6'd1, 32'hFFFF_FFFF, 8'h00);
		send(stbb_pkg::ACT_FINISH, 6'd0, 32'd0, 8'h00);
		send(stbb_pkg::ACT_FINISH, 6'h3F, 32'hFFFF_FFFF, 8'hFF);
		// Stray value byte on a fresh block.
		send(stbb_pkg::ACT_VALUE, 6'd0, 32'd0, 8'h33);
		drain();

		// Restart on every entry after the first until the offset table is full, then finish.
		idling = 1'b1;
		write_interval(16'd1);
		repeat (stbb_pkg::MAX_RESTARTS + 3) begin
			int kl;
			int vl;
			kl = int'($urandom_range(2, 0));
			vl = int'($urandom_range(1, 0));
			send_entry(kl, 32'(vl), kl, vl);
		end
		send(stbb_pkg::ACT_FINISH, 6'($urandom), $urandom, 8'($urandom));
		drain();

		// An interval of zero makes every entry a restart point.
		write_interval(16'd0);
		random_phase(50);
		drain();

		// Largest interval, with a long hold-off on the result side to back the block up.
		write_interval(16'hFFFF);
		hold_req = 1'b1;
		random_phase(60);
		drain();

		// Further phases with assorted intervals until the item budget is spent.
		while (transfers - noise_transfers < ITEMS) begin
			case ($urandom_range(5, 0))
				0: iv = 16'($urandom_range(4, 1));
				1: iv = 16'd0;
				2: iv = 16'hFFFF;
				3: iv = 16'($urandom_range(65535, 1));
				4: iv = 16'd2;
				default: iv = 16'd16;
			endcase
			write_interval(iv);
			idling = ($urandom_range(3, 0) != 0);
			random_phase(int'($urandom_range(60, 30)));
			drain();
		end

		$display("Run covered %0d input transfers (%0d of them noise) and %0d result transfers",
			transfers, noise_transfers, sb.checked);
		$display("over %0d interval settings, %0d finished blocks, %0d over-long keys,",
			settings, sb.finishes, sb.key_long_flags);
		$display("and %0d full restart tables.", sb.table_full_flags);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/stbb_pkg.sv
hw/rtl/stbb_key_store.sv
hw/rtl/sorted_table_block_builder.sv
tb/tb.sv
